// ===== rtl/scs_pkg.sv =====
// ----------------------------------------------------------------------------
// scs_pkg
// Types, constants and register defaults of the Super I/O config space.
// ----------------------------------------------------------------------------
package scs_pkg;

  localparam int NUM_DEVICES_DEF = 13;
  localparam int NUM_GLOBAL      = 48;
  localparam int NUM_SLOTS       = 5;

  localparam logic [7:0] KEY_UNLOCK0 = 8'h51;
  localparam logic [7:0] KEY_UNLOCK1 = 8'h23;
  localparam logic [7:0] KEY_EXIT    = 8'hbb;
  localparam logic [7:0] CHIP_ID_RST = 8'h40;

  localparam logic [7:0] REG_SRST   = 8'h02;
  localparam logic [7:0] REG_LDN    = 8'h07;
  localparam logic [7:0] REG_PROT0  = 8'h1f;
  localparam logic [7:0] REG_CHIPID = 8'h20;
  localparam logic [7:0] REG_PROT1  = 8'h21;
  localparam logic [7:0] REG_DIS    = 8'h22;
  localparam logic [7:0] REG_SWAP   = 8'h2d;
  localparam logic [7:0] REG_ACT    = 8'h30;
  localparam logic [7:0] REG_BASEH  = 8'h60;
  localparam logic [7:0] REG_BASEL  = 8'h61;
  localparam logic [7:0] REG_OPT0   = 8'hf0;
  localparam logic [7:0] REG_OPT1   = 8'hf1;

  localparam logic [3:0] DEV_FDC  = 4'd0;
  localparam logic [3:0] DEV_LPT  = 4'd3;
  localparam logic [3:0] DEV_UA   = 4'd4;
  localparam logic [3:0] DEV_UB   = 4'd5;
  localparam logic [3:0] DEV_KBC  = 4'd7;
  localparam logic [3:0] DEV_UC   = 4'd11;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic SEL_INDEX = 1'b0;

  typedef struct packed {
    logic       cmd;
    logic       port_sel;
    logic [7:0] wdata;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  rdata;
    logic        cfg_mode;
    logic        fdc_on;
    logic [11:0] fdc_base;
    logic        lpt_on;
    logic [11:0] lpt_base;
    logic [2:0]  par_mode;
    logic [11:0] uart0_base;
    logic [11:0] uart1_base;
    logic [11:0] uart2_base;
    logic [2:0]  uart_on;
  } out_word_t;

  typedef struct packed {
    logic load;
    logic exec;
    logic resp;
    logic clr;
  } ctrl_cmd_t;

  typedef struct packed {
    logic soft_rst;
    logic clr_last;
  } ctrl_sts_t;

  function automatic logic [7:0] glob_default(logic [5:0] idx);
    case (idx)
      6'h20:   return 8'h43;
      6'h21:   return 8'h15;
      6'h2d:   return 8'h20;
      default: return 8'h00;
    endcase
  endfunction

  function automatic logic [7:0] dev_default(logic [3:0] ld, logic [7:0] r);
    case ({ld, r})
      {4'd0, 8'h60}:  return 8'h03;
      {4'd0, 8'h61}:  return 8'hf0;
      {4'd0, 8'h70}:  return 8'h06;
      {4'd0, 8'h74}:  return 8'h02;
      {4'd0, 8'hf0}:  return 8'h08;
      {4'd0, 8'hf2}:  return 8'hff;
      {4'd3, 8'h60}:  return 8'h03;
      {4'd3, 8'h61}:  return 8'h78;
      {4'd3, 8'h70}:  return 8'h05;
      {4'd3, 8'h74}:  return 8'h04;
      {4'd3, 8'hf0}:  return 8'h8c;
      {4'd3, 8'hf1}:  return 8'h85;
      {4'd4, 8'h60}:  return 8'h03;
      {4'd4, 8'h61}:  return 8'hf8;
      {4'd4, 8'h70}:  return 8'h04;
      {4'd4, 8'hf2}:  return 8'h0c;
      {4'd5, 8'h60}:  return 8'h03;
      {4'd5, 8'h61}:  return 8'he8;
      {4'd5, 8'h70}:  return 8'h09;
      {4'd5, 8'hf0}:  return 8'h80;
      {4'd7, 8'h30}:  return 8'h01;
      {4'd7, 8'h70}:  return 8'h01;
      {4'd11, 8'h60}: return 8'h02;
      {4'd11, 8'h61}: return 8'hf8;
      {4'd11, 8'h70}: return 8'h03;
      {4'd11, 8'hf2}: return 8'h0c;
      {4'd12, 8'hf0}: return 8'h35;
      {4'd12, 8'hf1}: return 8'h14;
      {4'd12, 8'hf2}: return 8'h11;
      {4'd12, 8'hf3}: return 8'h71;
      {4'd12, 8'hf4}: return 8'h42;
      default:        return 8'h00;
    endcase
  endfunction

  // devices whose base/enable registers are mirrored in flops
  function automatic logic [3:0] slot_dev(int unsigned s);
    case (s)
      0:       return DEV_FDC;
      1:       return DEV_LPT;
      2:       return DEV_UA;
      3:       return DEV_UB;
      default: return DEV_UC;
    endcase
  endfunction

endpackage

// ===== rtl/scs_ram.sv =====
// ----------------------------------------------------------------------------
// scs_ram
// Generic simple dual port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module scs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/scs_ctrl.sv =====
// ----------------------------------------------------------------------------
// scs_ctrl
// Access sequencer: clear pass, execute, respond.
// ----------------------------------------------------------------------------
module scs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output scs_pkg::ctrl_cmd_t cmd,
  input  scs_pkg::ctrl_sts_t sts
);
  import scs_pkg::*;

  localparam logic [1:0] S_CLR  = 2'd0;
  localparam logic [1:0] S_IDLE = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_RESP = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR:  if (sts.clr_last) state_nxt = S_IDLE;
      S_IDLE: if (start) state_nxt = S_EXEC;
      S_EXEC: state_nxt = S_RESP;
      S_RESP: state_nxt = sts.soft_rst ? S_CLR : S_IDLE;
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy     = (state_r != S_IDLE);
  assign cmd.load = (state_r == S_IDLE) && start;
  assign cmd.exec = (state_r == S_EXEC);
  assign cmd.resp = (state_r == S_RESP);
  assign cmd.clr  = (state_r == S_CLR);

endmodule

// ===== rtl/scs_dp.sv =====
// ----------------------------------------------------------------------------
// scs_dp
// Register file, device RAM, unlock logic and decoded base outputs.
// ----------------------------------------------------------------------------
module scs_dp #(
  parameter int NUM_DEVICES = scs_pkg::NUM_DEVICES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  scs_pkg::ctrl_cmd_t  cmd,
  output scs_pkg::ctrl_sts_t  sts,
  input  scs_pkg::in_word_t   in_word,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata,
  output logic                out_valid,
  output scs_pkg::out_word_t  out_word
);
  import scs_pkg::*;

  localparam int DEPTH = NUM_DEVICES * 256;
  localparam int AW    = $clog2(DEPTH);
  localparam int LDW   = AW - 8;
  localparam int GAW   = $clog2(NUM_GLOBAL);

  in_word_t   in_r;
  logic [7:0] chip_id_r;
  logic       act_r, act_nxt;
  logic       arm_r, arm_nxt;
  logic [7:0] idx_r, idx_nxt;
  logic [7:0] ldn_r, ldn_nxt;
  logic [7:0] dis_r, dis_nxt;
  logic [7:0] swp_r, swp_nxt;
  logic [7:0] s30_r [NUM_SLOTS], s30_nxt [NUM_SLOTS];
  logic [7:0] s60_r [NUM_SLOTS], s60_nxt [NUM_SLOTS];
  logic [7:0] s61_r [NUM_SLOTS], s61_nxt [NUM_SLOTS];
  logic [7:0] lf0_r, lf0_nxt, lf1_r, lf1_nxt;
  logic       soft_r, soft_nxt;
  logic [AW-1:0] clr_cnt_r;
  logic [7:0] rpre_r, rpre_nxt;
  logic       rram_r, rram_nxt;
  logic       rglb_r, rglb_nxt;
  logic       ov_r;
  out_word_t  ow_r;

  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0]    wdat, ram_q;
  logic          gwe;
  logic [GAW-1:0] gwaddr, graddr;
  logic [7:0]    gwdat, gram_q;
  logic [7:0]    ld, v;
  logic          swap;

  scs_ram #(.WIDTH(8), .DEPTH(DEPTH)) u_ram (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdat),
    .raddr(raddr),
    .rdata(ram_q)
  );

  scs_ram #(.WIDTH(8), .DEPTH(NUM_GLOBAL)) u_gram (
    .clk  (clk),
    .we   (gwe),
    .waddr(gwaddr),
    .wdata(gwdat),
    .raddr(graddr),
    .rdata(gram_q)
  );

  assign ld     = ldn_r;
  assign raddr  = {ld[LDW-1:0], idx_r};
  assign graddr = idx_r[GAW-1:0];
  assign swap   = swp_r[5];

  always_comb begin
    act_nxt  = act_r;
    arm_nxt  = arm_r;
    idx_nxt  = idx_r;
    ldn_nxt  = ldn_r;
    dis_nxt  = dis_r;
    swp_nxt  = swp_r;
    s30_nxt  = s30_r;
    s60_nxt  = s60_r;
    s61_nxt  = s61_r;
    lf0_nxt  = lf0_r;
    lf1_nxt  = lf1_r;
    soft_nxt = soft_r;
    rpre_nxt = rpre_r;
    rram_nxt = 1'b0;
    rglb_nxt = 1'b0;
    we       = 1'b0;
    waddr    = raddr;
    wdat     = in_r.wdata;
    gwe      = 1'b0;
    gwaddr   = idx_r[GAW-1:0];
    gwdat    = in_r.wdata;
    v        = in_r.wdata;
    if (cmd.clr) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdat  = dev_default(4'(clr_cnt_r[AW-1:8]), clr_cnt_r[7:0]);
      if (clr_cnt_r < AW'(NUM_GLOBAL)) begin
        gwe    = 1'b1;
        gwaddr = clr_cnt_r[GAW-1:0];
        gwdat  = glob_default(clr_cnt_r[GAW-1:0]);
      end
    end
    if (cmd.load) begin
      soft_nxt = 1'b0;
    end
    if (cmd.exec) begin
      rpre_nxt = 8'h00;
      if (in_r.cmd == CMD_WRITE) begin
        if (in_r.port_sel == SEL_INDEX) begin
          if (!act_r && !arm_r && v == KEY_UNLOCK0) begin
            arm_nxt = 1'b1;
          end else if (!act_r && arm_r && v == KEY_UNLOCK1) begin
            act_nxt = 1'b1;
            arm_nxt = 1'b0;
          end else if (act_r) begin
            if (v == KEY_EXIT) act_nxt = 1'b0;
            else idx_nxt = v;
          end else begin
            arm_nxt = 1'b0;
          end
        end else if (act_r) begin
          if (idx_r < 8'(NUM_GLOBAL)) begin
            if (idx_r >= REG_PROT0 && idx_r <= REG_PROT1) begin
              // protected
            end else if (idx_r == REG_SRST) begin
              // global RAM defaults come back in the clearing pass
              if (v[0]) begin
                soft_nxt = 1'b1;
                act_nxt  = 1'b0;
                ldn_nxt  = glob_default(REG_LDN[5:0]);
                dis_nxt  = glob_default(REG_DIS[5:0]);
                swp_nxt  = glob_default(REG_SWAP[5:0]);
                for (int s = 0; s < NUM_SLOTS; s++) begin
                  s30_nxt[s] = dev_default(slot_dev(s), REG_ACT);
                  s60_nxt[s] = dev_default(slot_dev(s), REG_BASEH);
                  s61_nxt[s] = dev_default(slot_dev(s), REG_BASEL);
                end
                lf0_nxt = dev_default(DEV_LPT, REG_OPT0);
                lf1_nxt = dev_default(DEV_LPT, REG_OPT1);
              end
            end else begin
              gwe = 1'b1;
              if (idx_r == REG_LDN)  ldn_nxt = v;
              if (idx_r == REG_DIS)  dis_nxt = v;
              if (idx_r == REG_SWAP) swp_nxt = v;
            end
          end else if (ld < 8'(NUM_DEVICES) && !(idx_r[7:4] == 4'h7 && ld < 8'd3) &&
                       ld != 8'd1 && ld != 8'd2 && ld != 8'd6 && ld != 8'd8 &&
                       ld != 8'd9 && ld != 8'd10) begin
            if (ld[3:0] == DEV_KBC && idx_r == REG_OPT0) v = v & 8'hbf;
            we   = 1'b1;
            wdat = v;
            for (int s = 0; s < NUM_SLOTS; s++) begin
              if (ld[3:0] == slot_dev(s)) begin
                if (idx_r == REG_ACT)   s30_nxt[s] = v;
                if (idx_r == REG_BASEH) s60_nxt[s] = v;
                if (idx_r == REG_BASEL) s61_nxt[s] = v;
              end
            end
            if (ld[3:0] == DEV_LPT && idx_r == REG_OPT0) lf0_nxt = v;
            if (ld[3:0] == DEV_LPT && idx_r == REG_OPT1) lf1_nxt = v;
            if (idx_r == REG_ACT && v[0]) begin
              case (ld[3:0])
                DEV_FDC: dis_nxt[0] = 1'b0;
                DEV_LPT: dis_nxt[3] = 1'b0;
                DEV_UA:  dis_nxt[4] = 1'b0;
                DEV_UB:  dis_nxt[swap ? 6 : 5] = 1'b0;
                DEV_UC:  dis_nxt[swap ? 5 : 6] = 1'b0;
                default: ;
              endcase
            end
          end
        end
      end else if (!act_r) begin
        rpre_nxt = 8'hff;
      end else if (in_r.port_sel == SEL_INDEX) begin
        rpre_nxt = idx_r;
      end else if (idx_r < 8'(NUM_GLOBAL)) begin
        // disable bits are read from flops, since activate writes clear them only there
        if (idx_r == REG_CHIPID) rpre_nxt = chip_id_r;
        else if (idx_r == REG_DIS) rpre_nxt = dis_r;
        else rglb_nxt = 1'b1;
      end else if (ld >= 8'(NUM_DEVICES)) begin
        rpre_nxt = 8'hff;
      end else begin
        rram_nxt = 1'b1;
      end
    end
  end

  function automatic logic [12:0] base8(logic [7:0] hi, logic [7:0] lo,
                                        logic dis, logic [7:0] a30);
    logic [15:0] p;
    logic        on;
    p  = {hi, lo} & 16'hfff8;
    on = !dis && a30 != 8'h00 && p >= 16'h0100 && p <= 16'h0ff8;
    return {on, on ? p[11:0] : 12'd0};
  endfunction

  logic [12:0] fdc_b, ua_b, ub_b, uc_b, u1_b, u2_b;
  logic [7:0]  g22;
  logic [2:0]  lm_raw, lmode;
  logic        epp, lon;
  logic [15:0] lp, llim;

  always_comb begin
    g22  = dis_r;
    fdc_b = base8(s60_r[0], s61_r[0], g22[0], s30_r[0]);
    ua_b  = base8(s60_r[2], s61_r[2], g22[4], s30_r[2]);
    ub_b  = base8(s60_r[3], s61_r[3], swap ? g22[6] : g22[5], s30_r[3]);
    uc_b  = base8(s60_r[4], s61_r[4], swap ? g22[5] : g22[6], s30_r[4]);
    u1_b  = swap ? uc_b : ub_b;
    u2_b  = swap ? ub_b : uc_b;
    lm_raw = lf0_r[2:0];
    if (lm_raw == 3'd4 && lf1_r[7]) lm_raw = 3'd0;
    case (lm_raw)
      3'd0:         begin lmode = 3'd1; epp = 1'b0; end
      3'd1, 3'd5:   begin lmode = 3'd2; epp = 1'b1; end
      3'd2:         begin lmode = 3'd3; epp = 1'b0; end
      3'd3, 3'd7:   begin lmode = 3'd4; epp = 1'b1; end
      default:      begin lmode = 3'd0; epp = 1'b0; end
    endcase
    lp   = {s60_r[1], s61_r[1]} & (epp ? 16'hfff8 : 16'hfffc);
    llim = epp ? 16'h0ff8 : 16'h0ffc;
    lon  = !g22[3] && s30_r[1] != 8'h00 && lp >= 16'h0100 && lp <= llim;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) in_r <= in_word;
    rpre_r <= rpre_nxt;
    rram_r <= rram_nxt;
    rglb_r <= rglb_nxt;
    if (cmd.resp) begin
      ow_r.rdata      <= rram_r ? ram_q : (rglb_r ? gram_q : rpre_r);
      ow_r.cfg_mode   <= act_r;
      ow_r.fdc_on     <= fdc_b[12];
      ow_r.fdc_base   <= fdc_b[11:0];
      ow_r.lpt_on     <= lon;
      ow_r.lpt_base   <= lon ? lp[11:0] : 12'd0;
      ow_r.par_mode   <= lmode;
      ow_r.uart0_base <= ua_b[11:0];
      ow_r.uart1_base <= u1_b[11:0];
      ow_r.uart2_base <= u2_b[11:0];
      ow_r.uart_on    <= {u2_b[12], u1_b[12], ua_b[12]};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chip_id_r <= CHIP_ID_RST;
      act_r     <= 1'b0;
      arm_r     <= 1'b0;
      idx_r     <= 8'h00;
      soft_r    <= 1'b0;
      ov_r      <= 1'b0;
      clr_cnt_r <= '0;
      ldn_r     <= glob_default(REG_LDN[5:0]);
      dis_r     <= glob_default(REG_DIS[5:0]);
      swp_r     <= glob_default(REG_SWAP[5:0]);
      for (int s = 0; s < NUM_SLOTS; s++) begin
        s30_r[s] <= dev_default(slot_dev(s), REG_ACT);
        s60_r[s] <= dev_default(slot_dev(s), REG_BASEH);
        s61_r[s] <= dev_default(slot_dev(s), REG_BASEL);
      end
      lf0_r <= dev_default(DEV_LPT, REG_OPT0);
      lf1_r <= dev_default(DEV_LPT, REG_OPT1);
    end else begin
      if (cfg_we) chip_id_r <= cfg_wdata;
      act_r  <= act_nxt;
      arm_r  <= arm_nxt;
      idx_r  <= idx_nxt;
      soft_r <= soft_nxt;
      ov_r   <= cmd.resp;
      ldn_r  <= ldn_nxt;
      dis_r  <= dis_nxt;
      swp_r  <= swp_nxt;
      s30_r  <= s30_nxt;
      s60_r  <= s60_nxt;
      s61_r  <= s61_nxt;
      lf0_r  <= lf0_nxt;
      lf1_r  <= lf1_nxt;
      if (cmd.clr) clr_cnt_r <= sts.clr_last ? '0 : clr_cnt_r + 1'b1;
    end
  end

  assign sts.soft_rst = soft_r;
  assign sts.clr_last = (clr_cnt_r == AW'(DEPTH - 1));
  assign out_valid    = ov_r;
  assign out_word     = ow_r;

endmodule

// ===== rtl/superio_config_space_unit.sv =====
// ----------------------------------------------------------------------------
// superio_config_space_unit
// Super I/O configuration space behind an index port and a data port.
// ----------------------------------------------------------------------------
//  channel  ports                           handshake
//  in       start, busy, in_data            start && !busy
//  out      out_valid, out_data             one-cycle strobe
//  cfg      cfg_valid, cfg_ready, cfg_data  cfg_valid && cfg_ready
//
// Each access passes through accept, execute and respond; the result word
// shows in the cycle after respond, while the next access may already be taken.
// Global and device registers sit in RAMs with registered reads; the read
// issued in the execute cycle is taken in the respond cycle.
// After reset, and after a soft reset, a clearing pass loads the defaults
// into both RAMs over all NUM_DEVICES*256 device RAM addresses with busy high.
// The receiver cannot stall results.
module superio_config_space_unit #(
  parameter int NUM_DEVICES = scs_pkg::NUM_DEVICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  scs_pkg::in_word_t  in_data,
  output logic               out_valid,
  output scs_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_data
);
  import scs_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  assign cfg_ready = 1'b1;

  scs_ctrl u_ctrl (
    .clk  (clk),
    .rst_n(rst_n),
    .start(start),
    .busy (busy),
    .cmd  (cmd),
    .sts  (sts)
  );

  scs_dp #(.NUM_DEVICES(NUM_DEVICES)) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .sts      (sts),
    .in_word  (in_data),
    .cfg_we   (cfg_valid && cfg_ready),
    .cfg_wdata(cfg_data),
    .out_valid(out_valid),
    .out_word (out_data)
  );

`ifndef SYNTH
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy not raised after accept");
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  a_strobe_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy))
    else $error("result without a pending access");
`endif

endmodule

// ===== bench/superio_config_space_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// superio_config_space_checker
// Watches the access, result and chip id channels of the config space unit.
// Keeps its own copy of the register file, computes the expected result
// word of every accepted access and compares each result word field by
// field. The failure count and the number of outstanding words go to the top.
// ----------------------------------------------------------------------------
module superio_config_space_checker #(
  parameter int NUM_DEV = scs_pkg::NUM_DEVICES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic               busy,
  input  scs_pkg::in_word_t  in_data,
  input  logic               out_valid,
  input  scs_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  input  logic               cfg_ready,
  input  logic [7:0]         cfg_data,
  output int                 errors,
  output int                 pending
);
  import scs_pkg::*;

  logic [7:0] chip_id;
  logic       in_cfg;
  logic       armed;
  logic [7:0] sel_reg;
  logic [7:0] glob [NUM_GLOBAL];
  logic [7:0] dev [NUM_DEV][256];
  out_word_t  expected_words [$];

  assign pending = expected_words.size();

  function automatic void load_register_defaults();
    for (int i = 0; i < NUM_GLOBAL; i++) glob[i] = 8'h00;
    for (int d = 0; d < NUM_DEV; d++)
      for (int r = 0; r < 256; r++) dev[d][r] = 8'h00;
    glob[6'h20] = 8'h43; glob[6'h21] = 8'h15; glob[6'h2d] = 8'h20;
    dev[0][8'h60] = 8'h03; dev[0][8'h61] = 8'hf0; dev[0][8'h70] = 8'h06;
    dev[0][8'h74] = 8'h02; dev[0][8'hf0] = 8'h08; dev[0][8'hf2] = 8'hff;
    dev[3][8'h60] = 8'h03; dev[3][8'h61] = 8'h78; dev[3][8'h70] = 8'h05;
    dev[3][8'h74] = 8'h04; dev[3][8'hf0] = 8'h8c; dev[3][8'hf1] = 8'h85;
    dev[4][8'h60] = 8'h03; dev[4][8'h61] = 8'hf8; dev[4][8'h70] = 8'h04;
    dev[4][8'hf2] = 8'h0c;
    dev[5][8'h60] = 8'h03; dev[5][8'h61] = 8'he8; dev[5][8'h70] = 8'h09;
    dev[5][8'hf0] = 8'h80;
    dev[7][8'h30] = 8'h01; dev[7][8'h70] = 8'h01;
    dev[11][8'h60] = 8'h02; dev[11][8'h61] = 8'hf8; dev[11][8'h70] = 8'h03;
    dev[11][8'hf2] = 8'h0c;
    dev[12][8'hf0] = 8'h35; dev[12][8'hf1] = 8'h14; dev[12][8'hf2] = 8'h11;
    dev[12][8'hf3] = 8'h71; dev[12][8'hf4] = 8'h42;
    in_cfg = 1'b0;
  endfunction

  function automatic logic [15:0] dev_base(logic [3:0] ld);
    return {dev[ld][REG_BASEH], dev[ld][REG_BASEL]};
  endfunction

  function automatic void update_index(logic [7:0] v);
    if (!in_cfg && !armed && v == KEY_UNLOCK0) armed = 1'b1;
    else if (!in_cfg && armed && v == KEY_UNLOCK1) begin
      in_cfg = 1'b1;
      armed  = 1'b0;
    end else if (in_cfg) begin
      if (v == KEY_EXIT) in_cfg = 1'b0;
      else sel_reg = v;
    end else armed = 1'b0;
  endfunction

  function automatic void update_data(logic [7:0] v);
    logic [7:0] ld;
    bit         swp;
    if (!in_cfg) return;
    if (sel_reg < NUM_GLOBAL) begin
      if (sel_reg >= REG_PROT0 && sel_reg <= REG_PROT1) return;
      if (sel_reg == REG_SRST) begin
        if (v[0]) load_register_defaults();
        glob[REG_SRST[5:0]] = 8'h00;
      end else glob[sel_reg[5:0]] = v;
      return;
    end
    ld = glob[REG_LDN[5:0]];
    if (ld >= NUM_DEV) return;
    if (sel_reg[7:4] == 4'h7 && ld < 3) return;
    if (ld inside {1, 2, 6, 8, 9, 10}) return;
    if (ld[3:0] == DEV_KBC && sel_reg == REG_OPT0) v[6] = 1'b0;
    dev[ld[3:0]][sel_reg] = v;
    if (sel_reg != REG_ACT || !v[0]) return;
    swp = glob[REG_SWAP[5:0]][5];
    case (ld[3:0])
      DEV_FDC: glob[REG_DIS[5:0]][0] = 1'b0;
      DEV_LPT: glob[REG_DIS[5:0]][3] = 1'b0;
      DEV_UA:  glob[REG_DIS[5:0]][4] = 1'b0;
      DEV_UB:  glob[REG_DIS[5:0]][swp ? 6 : 5] = 1'b0;
      DEV_UC:  glob[REG_DIS[5:0]][swp ? 5 : 6] = 1'b0;
      default: ;
    endcase
  endfunction

  function automatic out_word_t predict_access(in_word_t w);
    out_word_t   o;
    logic [15:0] base, mask;
    logic [2:0]  m;
    logic [3:0]  ld;
    logic [7:0]  g22, ldn;
    bit          on;
    o = '0;
    if (w.cmd == CMD_WRITE) begin
      if (w.port_sel == SEL_INDEX) update_index(w.wdata);
      else update_data(w.wdata);
    end
    ldn = glob[REG_LDN[5:0]];
    if (w.cmd == CMD_WRITE) o.rdata = 8'h00;
    else if (!in_cfg) o.rdata = 8'hff;
    else if (w.port_sel == SEL_INDEX) o.rdata = sel_reg;
    else if (sel_reg < NUM_GLOBAL)
      o.rdata = (sel_reg == REG_CHIPID) ? chip_id : glob[sel_reg[5:0]];
    else if (ldn >= NUM_DEV) o.rdata = 8'hff;
    else o.rdata = dev[ldn[3:0]][sel_reg];
    o.cfg_mode = in_cfg;
    g22 = glob[REG_DIS[5:0]];

    base = dev_base(DEV_FDC) & 16'hfff8;
    on = !g22[0] && dev[DEV_FDC][REG_ACT] != 0 && base >= 16'h100 && base <= 16'hff8;
    o.fdc_on   = on;
    o.fdc_base = on ? base[11:0] : 12'h0;

    m = dev[DEV_LPT][REG_OPT0][2:0];
    if (m == 3'd4 && dev[DEV_LPT][REG_OPT1][7]) m = 3'd0;
    mask = 16'hfffc;
    case (m)
      3'd0:       o.par_mode = 3'd1;
      3'd1, 3'd5: begin o.par_mode = 3'd2; mask = 16'hfff8; end
      3'd2:       o.par_mode = 3'd3;
      3'd3, 3'd7: begin o.par_mode = 3'd4; mask = 16'hfff8; end
      default:    o.par_mode = 3'd0;
    endcase
    base = dev_base(DEV_LPT) & mask;
    on = !g22[3] && dev[DEV_LPT][REG_ACT] != 0 && base >= 16'h100 &&
         base <= (16'h0ffc & mask);
    o.lpt_on   = on;
    o.lpt_base = on ? base[11:0] : 12'h0;

    for (int u = 0; u < 3; u++) begin
      ld = (u == 0) ? DEV_UA : ((u == 1) ^ glob[REG_SWAP[5:0]][5]) ? DEV_UB : DEV_UC;
      base = dev_base(ld) & 16'hfff8;
      on = !g22[4+u] && dev[ld][REG_ACT] != 0 && base >= 16'h100 &&
           base <= 16'hff8;
      o.uart_on[u] = on;
      if (!on) base = 16'h0;
      case (u)
        0:       o.uart0_base = base[11:0];
        1:       o.uart1_base = base[11:0];
        default: o.uart2_base = base[11:0];
      endcase
    end
    return o;
  endfunction

  always @(posedge clk) begin
    out_word_t e;
    if (!rst_n) begin
      load_register_defaults();
      chip_id = CHIP_ID_RST;
      armed   = 1'b0;
      sel_reg = 8'h00;
      expected_words.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) chip_id = cfg_data;
      if (out_valid) begin
        if (expected_words.size() == 0) begin
          $error("result word with nothing expected");
          errors <= errors + 1;
        end else begin
          e = expected_words.pop_front();
          if (e !== out_data) begin
            errors <= errors + 1;
            if (e.rdata !== out_data.rdata)
              $error("rdata exp %h got %h", e.rdata, out_data.rdata);
            if (e.cfg_mode !== out_data.cfg_mode)
              $error("cfg_mode exp %h got %h", e.cfg_mode, out_data.cfg_mode);
            if (e.fdc_on !== out_data.fdc_on)
              $error("fdc_on exp %h got %h", e.fdc_on, out_data.fdc_on);
            if (e.fdc_base !== out_data.fdc_base)
              $error("fdc_base exp %h got %h", e.fdc_base, out_data.fdc_base);
            if (e.lpt_on !== out_data.lpt_on)
              $error("lpt_on exp %h got %h", e.lpt_on, out_data.lpt_on);
            if (e.lpt_base !== out_data.lpt_base)
              $error("lpt_base exp %h got %h", e.lpt_base, out_data.lpt_base);
            if (e.par_mode !== out_data.par_mode)
              $error("par_mode exp %h got %h", e.par_mode, out_data.par_mode);
            if (e.uart0_base !== out_data.uart0_base)
              $error("uart0_base exp %h got %h", e.uart0_base, out_data.uart0_base);
            if (e.uart1_base !== out_data.uart1_base)
              $error("uart1_base exp %h got %h", e.uart1_base, out_data.uart1_base);
            if (e.uart2_base !== out_data.uart2_base)
              $error("uart2_base exp %h got %h", e.uart2_base, out_data.uart2_base);
            if (e.uart_on !== out_data.uart_on)
              $error("uart_on exp %h got %h", e.uart_on, out_data.uart_on);
          end
        end
      end
      if (start && !busy) expected_words.push_back(predict_access(in_data));
    end
  end

endmodule

// ===== bench/superio_config_space_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// superio_config_space_unit_tb
// Drives host accesses into the config space unit: a directed part for the
// unlock, protection, soft reset and device rules, then random register
// sessions in bursts with gaps, with chip id changes between and within phases.
// ----------------------------------------------------------------------------
module superio_config_space_unit_tb;
  import scs_pkg::*;

  localparam logic CMD_READ = 1'b1;
  localparam logic SEL_DATA = 1'b1;
  localparam int   N_ITEMS  = 1500;
  // every access could follow a soft reset with its clearing pass
  localparam int   LIMIT    = N_ITEMS * (NUM_DEVICES_DEF * 256 + 64) * 4;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_word_t  in_data = '0;
  logic      out_valid;
  out_word_t out_data;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = 8'h00;
  int        errors, pending;
  int        n_items = 0;
  int        burst_left = 0;
  int        cycles = 0;

  always #5 clk = ~clk;

  superio_config_space_unit i_dut (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data
  );

  superio_config_space_checker i_chk (
    .clk, .rst_n, .start, .busy, .in_data, .out_valid, .out_data,
    .cfg_valid, .cfg_ready, .cfg_data, .errors, .pending
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  task automatic issue_access(logic c, logic s, logic [7:0] d);
    start   <= 1'b1;
    in_data <= '{cmd: c, port_sel: s, wdata: d};
    do @(posedge clk); while (busy);
    n_items++;
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = $urandom_range(0, 30);
      if ($urandom_range(0, 3) != 0) begin
        start <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
      end
    end
  endtask

  task automatic drain_words();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_chip_id(logic [7:0] v);
    drain_words();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic reg_write(logic [7:0] r, logic [7:0] v);
    issue_access(CMD_WRITE, SEL_INDEX, r);
    issue_access(CMD_WRITE, SEL_DATA, v);
  endtask

  task automatic unlock();
    issue_access(CMD_WRITE, SEL_INDEX, KEY_UNLOCK0);
    issue_access(CMD_WRITE, SEL_INDEX, KEY_UNLOCK1);
  endtask

  function automatic logic [7:0] pick_register();
    case ($urandom_range(0, 15))
      0:       return REG_LDN;
      1:       return REG_ACT;
      2:       return REG_BASEH;
      3:       return REG_BASEL;
      4:       return REG_OPT0;
      5:       return REG_OPT1;
      6:       return REG_DIS;
      7:       return REG_SWAP;
      8:       return ($urandom_range(0, 7) == 0) ? REG_SRST : REG_CHIPID;
      9:       return REG_PROT0 + 8'($urandom_range(0, 2));
      10:      return 8'h70 + 8'($urandom_range(0, 15));
      11, 12:  return 8'($urandom_range(0, 255));
      13:      return 8'($urandom_range(0, NUM_GLOBAL - 1));
      14:      return REG_CHIPID;
      default: return 8'($urandom_range(8'h30, 8'hff));
    endcase
  endfunction

  function automatic logic [7:0] pick_value(logic [7:0] r);
    if (r == REG_LDN && $urandom_range(0, 9) < 8) return 8'($urandom_range(0, 15));
    if (r == REG_BASEH && $urandom_range(0, 1)) return 8'($urandom_range(0, 16));
    if (r == REG_DIS && $urandom_range(0, 1)) return 8'h00;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic random_session();
    logic [7:0] r;
    int k;
    k = $urandom_range(0, 99);
    if (k < 8)
      issue_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   8'($urandom_range(0, 255)));
    else if (k < 12) begin
      issue_access(CMD_WRITE, SEL_INDEX, KEY_UNLOCK0);
      issue_access(CMD_WRITE, SEL_INDEX, 8'($urandom_range(0, 255)));
    end else if (k < 16) issue_access(CMD_WRITE, SEL_INDEX, KEY_EXIT);
    else if (k < 28) unlock();
    else begin
      r = pick_register();
      issue_access(CMD_WRITE, SEL_INDEX, r);
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 2) == 0)
          issue_access(CMD_READ, 1'($urandom_range(0, 1)), 8'h00);
        else issue_access(CMD_WRITE, SEL_DATA, pick_value(r));
      end
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    write_chip_id(8'hff);

    // reads outside config mode, broken unlock
    issue_access(CMD_READ, SEL_DATA, 8'h00);
    issue_access(CMD_WRITE, SEL_INDEX, KEY_UNLOCK0);
    issue_access(CMD_WRITE, SEL_INDEX, 8'h00);
    issue_access(CMD_WRITE, SEL_INDEX, KEY_UNLOCK1);
    issue_access(CMD_READ, SEL_INDEX, 8'h00);
    unlock();
    issue_access(CMD_READ, SEL_INDEX, 8'hff);
    reg_write(REG_CHIPID, 8'h00);
    issue_access(CMD_READ, SEL_DATA, 8'h00);
    reg_write(REG_PROT0, 8'hff);
    reg_write(REG_LDN, 8'd13);
    issue_access(CMD_READ, SEL_DATA, 8'h00);
    reg_write(REG_LDN, 8'(DEV_KBC));
    reg_write(REG_OPT0, 8'hff);
    reg_write(REG_LDN, 8'(DEV_FDC));
    reg_write(REG_DIS, 8'hff);
    reg_write(REG_ACT, 8'h01);
    reg_write(REG_SWAP, 8'h00);
    reg_write(REG_SRST, 8'h01);
    drain_words();
    issue_access(CMD_WRITE, SEL_INDEX, KEY_EXIT);
    write_chip_id(8'h00);

    while (n_items < N_ITEMS) begin
      random_session();
      if (n_items > 400 && n_items < 420) drain_words();
      if (n_items % 500 < 4 && n_items > 10)
        write_chip_id((n_items < 800) ? 8'hff : 8'($urandom_range(0, 255)));
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0 && pending == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
